### src/ptb_pkg.sv
// Shared types and constants for the page framebuffer text blitter.
`timescale 1ns / 1ps

package ptb_pkg;

   typedef logic [7:0] byte_type;

   // Input kinds
   localparam logic [1:0] KIND_CURSOR = 2'd0;
   localparam logic [1:0] KIND_NARROW = 2'd1;
   localparam logic [1:0] KIND_WIDE   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // Display controller address commands
   localparam byte_type CMD_COLUMN = 8'h80;
   localparam byte_type CMD_PAGE   = 8'h40;

   // Bits kept above the glyph on its end page, before the shift by the end offset
   localparam byte_type KEEP_END = 8'hFE;

   localparam int GLYPH_ROWS   = 12;
   localparam int NARROW_WIDTH = 6;
   localparam int WIDE_WIDTH   = 12;

   // Page passes of one glyph
   localparam logic [1:0] PASS_FIRST  = 2'd0;
   localparam logic [1:0] PASS_MIDDLE = 2'd1;
   localparam logic [1:0] PASS_END    = 2'd2;

endpackage

### src/page_framebuffer_text_blitter_top.sv
// Top level of the page framebuffer text blitter: sequencer, frame store and merge unit.
`timescale 1ns / 1ps

// A set-cursor word leaves busy low. A glyph keeps busy high while it works through
// each store page it touches (two or three, fewer near the bottom), sending a column
// command, a page command and one byte for each of its 6 or 12 columns. The frame
// store does one read-modify-write per column and cycle, writing back one column while
// it reads the next. Results come on rsp_strobe, one per cycle within a page pass, and
// cannot be held off; the last byte of a glyph carries rsp_last. After reset the store
// is cleared one byte per cycle, all PAGES * COLUMNS bytes (504 at the defaults), with
// busy high until it is done.
module page_framebuffer_text_blitter_top
   import ptb_pkg::*;
#(
   parameter int PAGES   = 6,
   parameter int COLUMNS = 84
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_start_row,
   input  logic [6:0]  req_start_column,
   input  logic [47:0] req_glyph_low_a,
   input  logic [47:0] req_glyph_low_b,
   input  logic [47:0] req_glyph_high_a,
   input  logic [47:0] req_glyph_high_b,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_command,
   output logic        rsp_last
);

   localparam int ROWS   = PAGES * 8;
   localparam int RW     = ($clog2(ROWS) > 6) ? $clog2(ROWS) : 6;
   localparam int PW     = RW - 2;
   localparam int CCW    = ($clog2(COLUMNS) > 7) ? $clog2(COLUMNS) : 7;
   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int AW     = $clog2(DEPTH);

   localparam logic [RW-1:0]  ROW_LIMIT = RW'(ROWS - GLYPH_ROWS);
   localparam logic [RW-1:0]  ROW_STEP  = RW'(GLYPH_ROWS);
   localparam logic [RW:0]    ROW_SPAN  = (RW + 1)'(GLYPH_ROWS - 1);
   localparam logic [PW-1:0]  PAGE_END  = PW'(PAGES);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_SETUP    = 3'd2;
   localparam logic [2:0] ST_PASS     = 3'd3;
   localparam logic [2:0] ST_CMD_COL  = 3'd4;
   localparam logic [2:0] ST_CMD_PAGE = 3'd5;
   localparam logic [2:0] ST_DATA     = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [CCW-1:0] cur_col_ff, cur_col_in;
   logic [3:0]     width_ff, width_in;
   byte_type       lo_ff [12];
   byte_type       lo_in [12];
   byte_type       hi_ff [12];
   byte_type       hi_in [12];
   logic [CCW-1:0] col_ff, col_in;
   logic [2:0]     ofs_ff, ofs_in;
   logic [2:0]     eofs_ff, eofs_in;
   logic           middle_ff, middle_in;
   logic [PW-1:0]  bpage_ff, bpage_in;
   logic [PW-1:0]  epage_ff, epage_in;
   logic [PW-1:0]  page_ff, page_in;
   logic [2:0]     en_ff, en_in;
   logic [1:0]     pass_ff, pass_in;
   logic [3:0]     col_idx_ff, col_idx_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           strobe_ff, strobe_in;
   byte_type       byte_ff, byte_in;
   logic           cmd_ff, cmd_in;
   logic           last_ff, last_in;

   byte_type       store_ff [DEPTH];
   byte_type       rd_ff;

   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   byte_type       mem_wdata;

   // Wrap and page geometry for the glyph at the cursor
   logic           wrap;
   logic [RW-1:0]  row_w;
   logic [CCW-1:0] col_w;
   logic [RW:0]    row_end;
   logic [PW-1:0]  bpage_w, epage_w, mpage_w;
   logic           middle_w;

   // Merge unit
   byte_type       lo_sel, hi_sel;
   logic [22:0]    word_sh;
   logic [15:0]    hi_sh, lo_sh;
   byte_type       low_mask, keep_mask, merged;
   logic [PW-1:0]  page_sel;
   logic           last_pass;

   always_comb begin
      wrap     = cur_col_ff >= (CCW'(COLUMNS) - CCW'(width_ff));
      row_w    = cur_row_ff;
      col_w    = cur_col_ff;
      if (wrap) begin
         row_w = (cur_row_ff < ROW_LIMIT) ? cur_row_ff + ROW_STEP : '0;
         col_w = '0;
      end
      row_end  = {1'b0, row_w} + ROW_SPAN;
      bpage_w  = PW'(row_w[RW-1:3]);
      epage_w  = row_end[RW:3];
      mpage_w  = bpage_w + PW'(1);
      middle_w = (epage_w - bpage_w) > PW'(1);
   end

   always_comb begin
      lo_sel    = lo_ff[col_idx_ff];
      hi_sel    = hi_ff[col_idx_ff];
      word_sh   = {7'b0, hi_sel, lo_sel} << ofs_ff;
      hi_sh     = {8'b0, hi_sel} << ofs_ff;
      lo_sh     = {8'b0, lo_sel} << ofs_ff;
      low_mask  = ~(8'hFF << ofs_ff);
      keep_mask = KEEP_END << eofs_ff;
      case (pass_ff)
         PASS_FIRST:  merged = (rd_ff & low_mask) | lo_sh[7:0];
         PASS_MIDDLE: merged = word_sh[15:8];
         default:     merged = (rd_ff & keep_mask) | (middle_ff ? hi_sh[15:8] : word_sh[15:8]);
      endcase
   end

   always_comb begin
      case (pass_ff)
         PASS_FIRST:  page_sel = bpage_ff;
         PASS_MIDDLE: page_sel = bpage_ff + PW'(1);
         default:     page_sel = epage_ff;
      endcase
      case (pass_ff)
         PASS_FIRST:  last_pass = !en_ff[1] && !en_ff[2];
         PASS_MIDDLE: last_pass = !en_ff[2];
         default:     last_pass = 1'b1;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      col_in     = col_ff;
      ofs_in     = ofs_ff;
      eofs_in    = eofs_ff;
      middle_in  = middle_ff;
      bpage_in   = bpage_ff;
      epage_in   = epage_ff;
      page_in    = page_ff;
      en_in      = en_ff;
      pass_in    = pass_ff;
      col_idx_in = col_idx_ff;
      base_in    = base_ff;
      clr_in     = clr_ff;
      strobe_in  = 1'b0;
      byte_in    = byte_ff;
      cmd_in     = cmd_ff;
      last_in    = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = base_ff + AW'(col_idx_ff);
      mem_raddr  = base_ff;
      mem_wdata  = merged;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_CURSOR: begin
                     cur_row_in = (RW'(req_start_row) > ROW_LIMIT) ? ROW_LIMIT
                                                                   : RW'(req_start_row);
                     cur_col_in = CCW'(req_start_column);
                  end
                  KIND_NARROW, KIND_WIDE: begin
                     width_in = (req_kind == KIND_NARROW) ? 4'(NARROW_WIDTH)
                                                           : 4'(WIDE_WIDTH);
                     for (int k = 0; k < 6; k++) begin
                        lo_in[k]     = req_glyph_low_a[8*k +: 8];
                        lo_in[k + 6] = req_glyph_low_b[8*k +: 8];
                        hi_in[k]     = req_glyph_high_a[8*k +: 8];
                        hi_in[k + 6] = req_glyph_high_b[8*k +: 8];
                     end
                     state_in = ST_SETUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SETUP: begin
            col_in     = col_w;
            ofs_in     = row_w[2:0];
            eofs_in    = row_end[2:0];
            middle_in  = middle_w;
            bpage_in   = bpage_w;
            epage_in   = epage_w;
            en_in      = {epage_w < PAGE_END, middle_w && (mpage_w < PAGE_END),
                          bpage_w < PAGE_END};
            pass_in    = PASS_FIRST;
            // cursor moves now; the rest of the glyph works from the latched copy
            cur_row_in = row_w;
            cur_col_in = col_w + CCW'(width_ff);
            state_in   = ST_PASS;
         end
         ST_PASS: begin
            if (en_ff[pass_ff]) begin
               page_in  = page_sel;
               base_in  = AW'(32'(page_sel) * COLUMNS + 32'(col_ff));
               state_in = ST_CMD_COL;
            end else if (pass_ff == PASS_END) begin
               state_in = ST_IDLE;
            end else begin
               pass_in = pass_ff + 2'd1;
            end
         end
         ST_CMD_COL: begin
            strobe_in = 1'b1;
            byte_in   = CMD_COLUMN | 8'(col_ff);
            cmd_in    = 1'b1;
            state_in  = ST_CMD_PAGE;
         end
         ST_CMD_PAGE: begin
            strobe_in  = 1'b1;
            byte_in    = CMD_PAGE | {4'b0, page_ff[3:0]};
            cmd_in     = 1'b1;
            mem_re     = 1'b1;
            col_idx_in = '0;
            state_in   = ST_DATA;
         end
         ST_DATA: begin
            // write back column j while column j+1 is read
            mem_we     = 1'b1;
            strobe_in  = 1'b1;
            byte_in    = merged;
            cmd_in     = 1'b0;
            col_idx_in = col_idx_ff + 4'd1;
            mem_raddr  = base_ff + AW'(col_idx_ff) + AW'(1);
            if (col_idx_ff == width_ff - 4'd1) begin
               last_in = last_pass;
               if (pass_ff == PASS_END) begin
                  state_in = ST_IDLE;
               end else begin
                  pass_in  = pass_ff + 2'd1;
                  state_in = ST_PASS;
               end
            end else begin
               mem_re = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= store_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         pass_ff    <= PASS_FIRST;
         col_idx_ff <= '0;
         clr_ff     <= '0;
         en_ff      <= '0;
         strobe_ff  <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         pass_ff    <= pass_in;
         col_idx_ff <= col_idx_in;
         clr_ff     <= clr_in;
         en_ff      <= en_in;
         strobe_ff  <= strobe_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff  <= width_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      col_ff    <= col_in;
      ofs_ff    <= ofs_in;
      eofs_ff   <= eofs_in;
      middle_ff <= middle_in;
      bpage_ff  <= bpage_in;
      epage_ff  <= epage_in;
      page_ff   <= page_in;
      base_ff   <= base_in;
      byte_ff   <= byte_in;
      cmd_ff    <= cmd_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_strobe     = strobe_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_command = cmd_ff;
   assign rsp_last       = last_ff;

endmodule

### src/ptb_checker.sv
// Port-level checks for the page framebuffer text blitter, bound to its top level.
`timescale 1ns / 1ps

module ptb_checker
   import ptb_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_kind,
   input logic       rsp_strobe,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_command,
   input logic       rsp_last
);

   // store clearing holds off work right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // a cursor word or an unused kind finishes at once
   a_quick_word: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_CURSOR || req_kind == KIND_NONE)) |=> !busy)
      else $error("non-glyph word left block busy");

   // a glyph word takes the block busy
   a_glyph_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_NARROW || req_kind == KIND_WIDE)) |=> busy)
      else $error("glyph word did not start work");

   // a column command is always followed by its page command
   a_page_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_command && rsp_out_byte[7])
      |=> (rsp_strobe && rsp_is_command && !rsp_out_byte[7] && rsp_out_byte[6]))
      else $error("column command not followed by page command");

   // nothing follows the last byte of a glyph directly
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result right after last byte");

endmodule

bind page_framebuffer_text_blitter_top ptb_checker u_ptb_checker (.*);

### test/tb_page_framebuffer_text_blitter_top.sv
// Self-checking testbench for the page framebuffer text blitter, with a predictor and a byte checker.
`timescale 1ns / 1ps

module tb_page_framebuffer_text_blitter_top
   import ptb_pkg::*;
();

   localparam int PAGES     = 6;
   localparam int COLUMNS   = 84;
   localparam int ROW_LIMIT = PAGES * 8 - GLYPH_ROWS;
   localparam int RANDOM_WORDS = 209;
   // Accepted-word window in which the driver never idles
   localparam int CALM_FIRST = 90;
   localparam int CALM_LAST  = 150;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  start_row;
      logic [6:0]  start_column;
      logic [47:0] glyph_low_a;
      logic [47:0] glyph_low_b;
      logic [47:0] glyph_high_a;
      logic [47:0] glyph_high_b;
   } glyph_word_type;

   typedef struct {
      byte_type out_byte;
      logic     is_command;
      logic     last;
   } sent_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_NONE;
   logic [5:0]  req_start_row = '0;
   logic [6:0]  req_start_column = '0;
   logic [47:0] req_glyph_low_a = '0;
   logic [47:0] req_glyph_low_b = '0;
   logic [47:0] req_glyph_high_a = '0;
   logic [47:0] req_glyph_high_b = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_command;
   logic        rsp_last;

   glyph_word_type pending_words[$];
   sent_byte_type  expected_bytes[$];
   byte_type       shadow_frame[PAGES * COLUMNS];
   int unsigned    text_row;
   int unsigned    text_column;
   int             accepted_count = 0;
   int             mismatch_count = 0;

   page_framebuffer_text_blitter_top #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_start_row    (req_start_row),
      .req_start_column (req_start_column),
      .req_glyph_low_a  (req_glyph_low_a),
      .req_glyph_low_b  (req_glyph_low_b),
      .req_glyph_high_a (req_glyph_high_a),
      .req_glyph_high_b (req_glyph_high_b),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_command   (rsp_is_command),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Update the shadow store and cursor for one word and queue the bytes it sends.
   task automatic blit_word(input glyph_word_type w);
      sent_byte_type burst[$];
      sent_byte_type sb;
      int unsigned width, r, c, b, o, e, eo, page, lo, hi, shifted, v, idx, keep, add;
      bit          middle;
      if (w.kind == KIND_CURSOR) begin
         text_row = (w.start_row > ROW_LIMIT) ? ROW_LIMIT : w.start_row;
         text_column = w.start_column;
      end else if (w.kind != KIND_NONE) begin
         width = (w.kind == KIND_NARROW) ? NARROW_WIDTH : WIDE_WIDTH;
         r = text_row;
         c = text_column;
         // wrap even when the glyph would just fit
         if (c >= COLUMNS - width) begin
            r = (r < ROW_LIMIT) ? r + GLYPH_ROWS : 0;
            c = 0;
         end
         b = r / 8;
         o = r % 8;
         e = (r + GLYPH_ROWS - 1) / 8;
         eo = (r + GLYPH_ROWS - 1) % 8;
         middle = (e - b) > 1;
         for (int p = 0; p < 3; p++) begin
            if (p == PASS_MIDDLE && !middle) continue;
            page = (p == PASS_FIRST) ? b : (p == PASS_MIDDLE) ? b + 1 : e;
            // drop pages below the bottom of the store
            if (page >= PAGES) continue;
            sb.last = 1'b0;
            sb.is_command = 1'b1;
            sb.out_byte = CMD_COLUMN | byte_type'(c);
            burst.push_back(sb);
            sb.out_byte = CMD_PAGE | byte_type'(page);
            burst.push_back(sb);
            sb.is_command = 1'b0;
            for (int j = 0; j < width; j++) begin
               lo = (j < 6) ? w.glyph_low_a[8*j +: 8] : w.glyph_low_b[8*(j-6) +: 8];
               hi = (j < 6) ? w.glyph_high_a[8*j +: 8] : w.glyph_high_b[8*(j-6) +: 8];
               shifted = ((hi << 8) | lo) << o;
               idx = page * COLUMNS + c + j;
               v = shadow_frame[idx];
               if (p == PASS_FIRST) begin
                  v = (v & ((1 << o) - 1)) | ((lo << o) & 8'hFF);
               end else if (p == PASS_MIDDLE) begin
                  v = (shifted >> 8) & 8'hFF;
               end else begin
                  keep = (int'(KEEP_END) << eo) & 8'hFF;
                  add = middle ? (((hi << o) >> 8) & 8'hFF) : ((shifted >> 8) & 8'hFF);
                  v = (v & keep) | add;
               end
               shadow_frame[idx] = byte_type'(v);
               sb.out_byte = byte_type'(v);
               burst.push_back(sb);
            end
         end
         if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
         foreach (burst[k]) expected_bytes.push_back(burst[k]);
         text_row = r;
         text_column = c + width;
      end
   endtask

   task automatic queue_word(input logic [1:0] kind, input logic [5:0] row,
                             input logic [6:0] column, input logic [47:0] la,
                             input logic [47:0] lb, input logic [47:0] ha,
                             input logic [47:0] hb);
      glyph_word_type w;
      w.kind = kind;
      w.start_row = row;
      w.start_column = column;
      w.glyph_low_a = la;
      w.glyph_low_b = lb;
      w.glyph_high_a = ha;
      w.glyph_high_b = hb;
      pending_words.push_back(w);
   endtask

   function automatic logic [47:0] glyph_bits();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 6) return '0;
      if (pick < 12) return '1;
      return 48'({$urandom, $urandom});
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Driver: present the oldest pending word, idling at random outside the calm window.
   always @(posedge clock) begin : driver
      glyph_word_type nxt;
      bit             hold_off;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            blit_word(pending_words.pop_front());
            accepted_count++;
         end
         hold_off = (accepted_count < CALM_FIRST || accepted_count >= CALM_LAST)
                    && ($urandom_range(99) < 22);
         if (pending_words.size() != 0 && !hold_off) begin
            nxt = pending_words[0];
            start <= 1'b1;
            req_kind <= nxt.kind;
            req_start_row <= nxt.start_row;
            req_start_column <= nxt.start_column;
            req_glyph_low_a <= nxt.glyph_low_a;
            req_glyph_low_b <= nxt.glyph_low_b;
            req_glyph_high_a <= nxt.glyph_high_a;
            req_glyph_high_b <= nxt.glyph_high_b;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check every strobed byte against the oldest expectation.
   always @(posedge clock) begin : monitor
      sent_byte_type want;
      if (!reset && rsp_strobe) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h cmd %b last %b",
                                      rsp_out_byte, rsp_is_command, rsp_last));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_is_command !== want.is_command ||
                rsp_last !== want.last)
               report_mismatch($sformatf("expected byte %h cmd %b last %b, got %h %b %b",
                                         want.out_byte, want.is_command, want.last,
                                         rsp_out_byte, rsp_is_command, rsp_last));
         end
      end
   end

   initial begin
      int          glyphs;
      int unsigned pick;
      logic [5:0]  row;
      logic [6:0]  column;
      for (int i = 0; i < PAGES * COLUMNS; i++) shadow_frame[i] = '0;
      text_row = 0;
      text_column = 0;

      // directed words
      queue_word(KIND_NARROW, 0, 0, '1, '0, '1, '0);
      queue_word(KIND_WIDE, 0, 0, '1, '1, '1, '1);
      queue_word(KIND_CURSOR, 5, 20, '0, '0, '0, '0);
      queue_word(KIND_WIDE, 0, 0, 48'hA55A_0FF0_3CC3, 48'h8001_7E7E_1248,
                 48'h0F0F_F0F0_5AA5, 48'hFFFF_0000_C33C);
      queue_word(KIND_CURSOR, 7, 0, '0, '0, '0, '0);
      queue_word(KIND_WIDE, 0, 0, '0, '0, '0, '0);
      queue_word(KIND_CURSOR, 63, 0, '0, '0, '0, '0);
      queue_word(KIND_NARROW, 0, 0, '1, '0, 48'hF0F0_F0F0_F0F0, '0);
      queue_word(KIND_CURSOR, 48, 30, '0, '0, '0, '0);
      queue_word(KIND_WIDE, 0, 0, glyph_bits(), glyph_bits(), glyph_bits(), glyph_bits());
      queue_word(KIND_CURSOR, 35, 72, '0, '0, '0, '0);
      queue_word(KIND_WIDE, 0, 0, '1, '1, '1, '1);
      queue_word(KIND_CURSOR, 36, 78, '0, '0, '0, '0);
      queue_word(KIND_NARROW, 0, 0, '1, '1, '1, '1);
      queue_word(KIND_CURSOR, 0, 127, '0, '0, '0, '0);
      queue_word(KIND_NARROW, 0, 0, glyph_bits(), '0, glyph_bits(), '0);
      queue_word(KIND_CURSOR, 24, 71, '0, '0, '0, '0);
      queue_word(KIND_WIDE, 0, 0, glyph_bits(), glyph_bits(), glyph_bits(), glyph_bits());
      queue_word(KIND_WIDE, 0, 0, glyph_bits(), glyph_bits(), glyph_bits(), glyph_bits());
      queue_word(KIND_NONE, 63, 127, '1, '1, '1, '1);
      queue_word(KIND_NARROW, 0, 0, 48'h0102_0408_1020, '0, 48'hF080_4020_1008, '0);

      // random words: mostly glyph runs that wrap lines, with cursor moves mixed in
      glyphs = 0;
      while (glyphs < RANDOM_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            row = ($urandom_range(9) == 0) ? 6'($urandom_range(37, 63))
                                           : 6'($urandom_range(0, ROW_LIMIT));
            column = ($urandom_range(9) == 0) ? 7'($urandom_range(84, 127))
                                              : 7'($urandom_range(0, COLUMNS - 1));
            queue_word(KIND_CURSOR, row, column, glyph_bits(), glyph_bits(),
                       glyph_bits(), glyph_bits());
            glyphs++;
         end else if (pick < 16) begin
            queue_word(KIND_NONE, 6'($urandom), 7'($urandom), glyph_bits(), glyph_bits(),
                       glyph_bits(), glyph_bits());
            glyphs++;
         end else begin
            queue_word((pick < 58) ? KIND_NARROW : KIND_WIDE, 6'($urandom), 7'($urandom),
                       glyph_bits(), glyph_bits(), glyph_bits(), glyph_bits());
            glyphs++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_bytes.size() != 0) @(posedge clock);
      // let a trailing glyph or cursor word drain
      repeat (64) @(posedge clock);

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
